// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the character decode for the crypt-alphabet
// base64 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

   // alphabet bounds and the pad character
   localparam logic [7:0] CHAR_DOT   = 8'h2e;  // '.'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;  // 'Z'
   localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LOW_Z = 8'h7a;  // 'z'
   localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='

   // sextet values where the letter ranges start
   localparam logic [5:0] SEXTET_UP_BASE  = 6'd12;
   localparam logic [5:0] SEXTET_LOW_BASE = 6'd38;

   // leftover-bit masks for one and two decoded bytes
   localparam logic [5:0] LEFTOVER_MASK_ONE = 6'h0f;
   localparam logic [5:0] LEFTOVER_MASK_TWO = 6'h03;

   // group positions
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   // csr map
   localparam int          CSR_ADDR_WIDTH = 3;
   localparam int          CSR_DATA_WIDTH = 32;
   localparam logic        CSR_ALLOW_MISSING_PADDING   = 1'b0;
   localparam logic        CSR_IGNORE_NONZERO_PAD_BITS = 1'b1;

   // command queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // one command: up to three words to send
   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] last_index;
      logic       data_valid;
      logic       eos;
      logic       err;
   } b64d_cmd_type;

   typedef struct packed {
      logic [5:0] value;
      logic       ok;
   } b64d_sextet_type;

   function automatic b64d_sextet_type decode_sextet(input logic [7:0] ch);
      b64d_sextet_type res;
      res.ok    = 1'b1;
      res.value = '0;
      if (ch >= CHAR_DOT && ch <= CHAR_NINE) begin
         res.value = 6'(ch - CHAR_DOT);
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
         res.value = 6'(ch - CHAR_UP_A) + SEXTET_UP_BASE;
      end else if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
         res.value = 6'(ch - CHAR_LOW_A) + SEXTET_LOW_BASE;
      end else begin
         res.ok = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/b64d_req_if.sv
// ----------------------------------------------------------------------------
// b64d_req_if
// character channel into the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       final_char;

   modport source (output valid, output in_char, output final_char, input ready);
   modport sink   (input valid, input in_char, input final_char, output ready);
endinterface

`default_nettype wire

// File: src/b64d_rsp_if.sv
// ----------------------------------------------------------------------------
// b64d_rsp_if
// decoded word channel out of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_stream;
   logic       decode_error;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_stream, output decode_error, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_stream, input decode_error, output ready);
endinterface

`default_nettype wire

// File: src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// takes characters, tracks the group of four and builds output commands
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   b64d_req_if.sink    req,
   input  wire logic   allow_missing_padding,
   input  wire logic   ignore_nonzero_pad_bits,
   input  wire logic   queue_full,
   output logic        push,
   output b64d_cmd_type push_cmd
);

   logic [1:0]      group_pos_ff, group_pos_in;
   logic [5:0]      held_ff [3];
   logic [5:0]      held_in [3];
   logic            third_pad_ff, third_pad_in;
   logic            err_seen_ff, err_seen_in;
   logic            accept;
   logic            is_pad;
   b64d_sextet_type dec;
   logic [5:0]      c0, c1, c2, c3;
   logic [1:0]      n;
   logic            err;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign dec       = decode_sextet(req.in_char);
   assign is_pad    = (req.in_char == CHAR_PAD);

   always_comb begin
      group_pos_in = group_pos_ff;
      held_in      = held_ff;
      third_pad_in = third_pad_ff;
      err_seen_in  = err_seen_ff;
      push         = 1'b0;
      push_cmd     = '0;
      c0  = held_ff[0];
      c1  = held_ff[1];
      c2  = held_ff[2];
      c3  = dec.value;
      n   = 2'd0;
      err = err_seen_ff;

      if (!req.final_char) begin
         if (group_pos_ff != POS_FOURTH) begin
            if (group_pos_ff == POS_THIRD && is_pad) begin
               held_in[2]   = '0;
               third_pad_in = 1'b1;
            end else begin
               if (!dec.ok) err_seen_in = 1'b1;
               case (group_pos_ff)
                  POS_FIRST:  held_in[0] = dec.value;
                  POS_SECOND: held_in[1] = dec.value;
                  default:    held_in[2] = dec.value;
               endcase
            end
            group_pos_in = group_pos_ff + 2'd1;
         end else begin
            // full group: three words, error reported later at end of string
            if (!dec.ok || third_pad_ff) err_seen_in = 1'b1;
            push                = 1'b1;
            push_cmd.data0      = {c0, c1[5:4]};
            push_cmd.data1      = {c1[3:0], c2[5:2]};
            push_cmd.data2      = {c2[1:0], c3};
            push_cmd.last_index = 2'd2;
            push_cmd.data_valid = 1'b1;
            group_pos_in        = POS_FIRST;
            third_pad_in        = 1'b0;
         end
      end else begin
         c1 = (group_pos_ff == POS_SECOND) ? dec.value : held_ff[1];
         c2 = (group_pos_ff == POS_THIRD) ? dec.value : '0;
         c3 = '0;
         case (group_pos_ff)
            POS_FIRST: begin
               err = 1'b1;
            end
            POS_SECOND, POS_THIRD: begin
               if (!allow_missing_padding || !dec.ok) err = 1'b1;
               n = group_pos_ff;
            end
            default: begin
               c2 = held_ff[2];
               if (third_pad_ff) begin
                  c2 = '0;
                  if (is_pad) begin
                     n = 2'd1;
                  end else begin
                     err = 1'b1;
                     n   = 2'd2;
                  end
               end else if (is_pad) begin
                  n = 2'd2;
               end else begin
                  if (!dec.ok) err = 1'b1;
                  c3 = dec.value;
                  n  = 2'd3;
               end
            end
         endcase
         if (!ignore_nonzero_pad_bits) begin
            if (n == 2'd1 && (c1 & LEFTOVER_MASK_ONE) != '0) err = 1'b1;
            if (n == 2'd2 && (c2 & LEFTOVER_MASK_TWO) != '0) err = 1'b1;
         end
         push         = 1'b1;
         push_cmd.eos = 1'b1;
         push_cmd.err = err;
         if (n != 2'd0) begin
            push_cmd.data0      = {c0, c1[5:4]};
            push_cmd.data1      = {c1[3:0], c2[5:2]};
            push_cmd.data2      = {c2[1:0], c3};
            push_cmd.last_index = n - 2'd1;
            push_cmd.data_valid = 1'b1;
         end
         group_pos_in = POS_FIRST;
         third_pad_in = 1'b0;
         err_seen_in  = 1'b0;
      end

      if (!accept) begin
         group_pos_in = group_pos_ff;
         held_in      = held_ff;
         third_pad_in = third_pad_ff;
         err_seen_in  = err_seen_ff;
         push         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= POS_FIRST;
         third_pad_ff <= 1'b0;
         err_seen_ff  <= 1'b0;
      end else begin
         group_pos_ff <= group_pos_in;
         third_pad_ff <= third_pad_in;
         err_seen_ff  <= err_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

// File: src/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire b64d_cmd_type  push_cmd,
   input  wire logic          pop,
   output logic               full,
   output logic               empty,
   output b64d_cmd_type       head
);

   b64d_cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      if (!push && pop) count_in = count_ff - QUEUE_CNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// File: src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// plays each command out as one to three words on the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          queue_empty,
   input  wire b64d_cmd_type  head,
   output logic               pop,
   b64d_rsp_if.source         rsp
);

   b64d_cmd_type cur_ff, cur_in;
   logic [1:0]   idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic         last;
   logic         sent;

   assign last = (idx_ff == cur_ff.last_index);
   assign sent = busy_ff && rsp.ready;
   assign pop  = !queue_empty && (!busy_ff || (sent && last));

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop) begin
         cur_in  = head;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (sent) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp.out_byte = cur_ff.data0;
         2'd1:    rsp.out_byte = cur_ff.data1;
         default: rsp.out_byte = cur_ff.data2;
      endcase
   end

   assign rsp.valid         = busy_ff;
   assign rsp.byte_valid    = cur_ff.data_valid;
   assign rsp.end_of_stream = cur_ff.eos && last;
   assign rsp.decode_error  = cur_ff.err && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

// File: src/base64_crypt_alphabet_decoder.sv
// ----------------------------------------------------------------------------
// base64_crypt_alphabet_decoder
// streaming base64 decoder for the crypt alphabet ./0-9A-Za-z, one character in
// per cycle while the queue has room, decoded bytes out while rsp is ready, one word per cycle
// ----------------------------------------------------------------------------
//
//   channel   direction   word carries                      handshake
//   -------   ---------   -------------------------------   -------------
//   req_chan  in          in_char, final_char               valid / ready
//   rsp_chan  out         out_byte, byte_valid,             valid / ready
//                         end_of_stream, decode_error
//   csr       in/out      two 1-bit control registers       apb, pready=1
//
// - one character is taken every cycle while the command queue has room
// - an item giving results leaves the front in the cycle it is taken; the back
//   sends one word per cycle while rsp is ready, so a full group is three rsp words
// - the four-entry command queue decouples the two sides, and the back's
//   command register holds the word on a rsp stall
// - synchronous active-high reset; no clearing pass, ready the cycle after
//
`default_nettype none

module base64_crypt_alphabet_decoder
   import b64d_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   b64d_req_if.sink                       req_chan,
   b64d_rsp_if.source                     rsp_chan,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   // control registers
   logic allow_pad_ff, allow_pad_in;
   logic ignore_bits_ff, ignore_bits_in;
   logic csr_write;
   logic csr_index;

   // front to queue to back
   logic         push;
   b64d_cmd_type push_cmd;
   logic         queue_full;
   logic         queue_empty;
   logic         pop;
   b64d_cmd_type head;

   // csr port: register i at byte address 4*i
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      allow_pad_in   = allow_pad_ff;
      ignore_bits_in = ignore_bits_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ALLOW_MISSING_PADDING:   allow_pad_in   = pwdata[0];
            CSR_IGNORE_NONZERO_PAD_BITS: ignore_bits_in = pwdata[0];
            default:                     allow_pad_in   = allow_pad_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_ALLOW_MISSING_PADDING:   prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, allow_pad_ff};
         CSR_IGNORE_NONZERO_PAD_BITS: prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, ignore_bits_ff};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_pad_ff   <= 1'b0;
         ignore_bits_ff <= 1'b0;
      end else begin
         allow_pad_ff   <= allow_pad_in;
         ignore_bits_ff <= ignore_bits_in;
      end
   end

   // front: alphabet decode, group tracking, command build
   b64d_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req                     (req_chan),
      .allow_missing_padding   (allow_pad_ff),
      .ignore_nonzero_pad_bits (ignore_bits_ff),
      .queue_full              (queue_full),
      .push                    (push),
      .push_cmd                (push_cmd)
   );

   // short queue so each side stalls on its own
   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // back: one word per cycle from the current command, while rsp is ready
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   // no push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("command pushed into full queue");

   // a pop hands the back a command it shows in the next cycle
   assert property (@(posedge clock) disable iff (reset) pop |=> rsp_chan.valid)
      else $error("popped command not shown");

   // a sent data word that does not end the string is followed at once while the queue holds work
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.end_of_stream
       && !rsp_chan.decode_error && rsp_chan.byte_valid && !queue_empty)
      |=> rsp_chan.valid)
      else $error("gap in output with work pending");

   // nothing is shown right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the crypt-alphabet base64 decoder: a queue-fed
// character driver, a word monitor checked against a local decode predictor,
// apb register writes between phases, random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import b64d_pkg::*;
();

   localparam int RSP_HOLD_CYCLES = 300;   // long rsp hold-off, fills the block
   localparam int SETTLE_CYCLES   = 8;     // quiet time before a register write
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int PHASE_CHARS     = 9;     // minimum characters per random phase
   localparam int PRINT_CAP       = 40;
   localparam int FILL_COMMANDS   = 8;     // lone finals pushed under the hold

   // register settings per random phase, bit p is phase p
   localparam bit [0:7] ALLOW_PLAN  = 8'b0101_1001;
   localparam bit [0:7] IGNORE_PLAN = 8'b0011_1010;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // shapes of the last group of a generated string
   typedef enum int {
      TAIL_FULL, TAIL_TWO_PADS, TAIL_ONE_PAD, TAIL_TWO_BARE,
      TAIL_THREE_BARE, TAIL_LONE, TAIL_PAD_THEN_CHAR
   } tail_shape_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       final_char;
   } char_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_stream;
      logic       decode_error;
   } word_type;

   logic clock = 1'b0;
   logic reset;

   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   b64d_req_if req_chan();
   b64d_rsp_if rsp_chan();

   base64_crypt_alphabet_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // stimulus and expectation stores
   char_item_type pending_chars[$];
   word_type      expected_words[$];
   int            chars_left;      // pushed but not yet taken by the block
   int            phase_chars;
   int            error_count;
   int            words_seen;

   // idling knobs, percent of cycles
   int send_idle_pct;
   int recv_stall_pct;

   // long rsp hold-off, requested by ticket, counted in its own process
   int hold_ticket;
   int hold_served;
   int hold_left;
   int quiet_cycles;

   // predictor state: decoder registers and group progress
   logic       cfg_allow_missing;
   logic       cfg_ignore_leftover;
   logic [1:0] grp_pos;
   logic [5:0] grp_sextet[3];
   logic       grp_third_pad;
   logic       str_error;

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("mismatch: %s", msg);
      end
   endtask

   // crypt alphabet lookup, ok low for anything outside it
   function automatic logic [5:0] char_sextet(input logic [7:0] ch, output logic ok);
      int c;
      c  = int'(ch);
      ok = 1'b1;
      if (c >= int'(CHAR_LOW_A) && c <= int'(CHAR_LOW_Z)) begin
         return 6'(c - int'(CHAR_LOW_A) + 38);
      end
      if (c >= int'(CHAR_UP_A) && c <= int'(CHAR_UP_Z)) begin
         return 6'(c - int'(CHAR_UP_A) + 12);
      end
      if (c >= int'(CHAR_DOT) && c <= int'(CHAR_NINE)) begin
         return 6'(c - int'(CHAR_DOT));
      end
      ok = 1'b0;
      return 6'd0;
   endfunction

   // inverse lookup, used to build well-formed strings
   function automatic logic [7:0] sextet_char(input logic [5:0] sx);
      if (sx < 6'd12) begin
         return CHAR_DOT + 8'(sx);
      end else if (sx < 6'd38) begin
         return CHAR_UP_A + 8'(sx - 6'd12);
      end
      return CHAR_LOW_A + 8'(sx - 6'd38);
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic v,
                                     input logic eos, input logic err);
      word_type w;
      w.out_byte      = b;
      w.byte_valid    = v;
      w.end_of_stream = eos;
      w.decode_error  = err;
      expected_words.push_back(w);
   endfunction

   // decode one taken character, queue the words it causes
   function automatic void decode_char(input char_item_type it);
      logic [5:0] sx, c1, c2, c3;
      logic [7:0] b[3];
      logic       ok, is_pad, err;
      int         n;
      sx     = char_sextet(it.in_char, ok);
      is_pad = (it.in_char == CHAR_PAD);
      if (!it.final_char) begin
         if (grp_pos != POS_FOURTH) begin
            if (grp_pos == POS_THIRD && is_pad) begin
               grp_sextet[2] = 6'd0;
               grp_third_pad = 1'b1;
            end else begin
               if (!ok) str_error = 1'b1;
               grp_sextet[grp_pos] = sx;
            end
            grp_pos = grp_pos + 2'd1;
            return;
         end
         // complete middle group: three words, error only at end of string
         if (!ok || grp_third_pad) str_error = 1'b1;
         push_word({grp_sextet[0], grp_sextet[1][5:4]}, 1'b1, 1'b0, 1'b0);
         push_word({grp_sextet[1][3:0], grp_sextet[2][5:2]}, 1'b1, 1'b0, 1'b0);
         push_word({grp_sextet[2][1:0], sx}, 1'b1, 1'b0, 1'b0);
         grp_pos       = POS_FIRST;
         grp_third_pad = 1'b0;
         return;
      end

      // final character closes the string
      err = str_error;
      c1  = (grp_pos == POS_SECOND) ? sx : grp_sextet[1];
      c2  = (grp_pos == POS_THIRD) ? sx : 6'd0;
      c3  = 6'd0;
      n   = 0;
      case (grp_pos)
         POS_FIRST: begin
            err = 1'b1;
         end
         POS_SECOND, POS_THIRD: begin
            if (!cfg_allow_missing || !ok) err = 1'b1;
            n = int'(grp_pos);
         end
         default: begin
            c2 = grp_sextet[2];
            if (grp_third_pad) begin
               c2 = 6'd0;
               if (is_pad) begin
                  n = 1;
               end else begin
                  err = 1'b1;
                  n   = 2;
               end
            end else if (is_pad) begin
               n = 2;
            end else begin
               if (!ok) err = 1'b1;
               c3 = sx;
               n  = 3;
            end
         end
      endcase
      if (!cfg_ignore_leftover) begin
         if (n == 1 && (c1 & LEFTOVER_MASK_ONE) != 6'd0) err = 1'b1;
         if (n == 2 && (c2 & LEFTOVER_MASK_TWO) != 6'd0) err = 1'b1;
      end
      grp_pos       = POS_FIRST;
      grp_third_pad = 1'b0;
      str_error     = 1'b0;
      if (n == 0) begin
         push_word(8'd0, 1'b0, 1'b1, err);
         return;
      end
      b[0] = {grp_sextet[0], c1[5:4]};
      b[1] = {c1[3:0], c2[5:2]};
      b[2] = {c2[1:0], c3};
      for (int i = 0; i < n; i++) begin
         push_word(b[i], 1'b1, i == n - 1, (i == n - 1) && err);
      end
   endfunction

   function automatic void push_char(input logic [7:0] ch, input logic fin);
      char_item_type it;
      it.in_char    = ch;
      it.final_char = fin;
      pending_chars.push_back(it);
      chars_left++;
      phase_chars++;
   endfunction

   function automatic void push_text(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], fin && (i == s.len() - 1));
      end
   endfunction

   // mostly alphabet, with some pads and raw bytes mixed in
   function automatic logic [7:0] rand_sym();
      int r;
      r = $urandom_range(99);
      if (r < 3) return CHAR_PAD;
      if (r < 7) return 8'($urandom_range(255));
      return sextet_char(6'($urandom_range(63)));
   endfunction

   // one encoded string: middle groups, then a last group of some shape; at times pure noise
   function automatic void gen_string();
      int             len;
      int             groups;
      tail_shape_type shape;
      logic [5:0]     low_sx;
      if ($urandom_range(99) < 6) begin
         // pure noise string
         len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            push_char(8'($urandom_range(255)), i == len - 1);
         end
         return;
      end
      groups = $urandom_range(0, 2);
      repeat (groups) begin
         push_char(rand_sym(), 1'b0);
         push_char(rand_sym(), 1'b0);
         push_char(($urandom_range(19) == 0) ? CHAR_PAD : rand_sym(), 1'b0);
         push_char(rand_sym(), 1'b0);
      end
      low_sx = 6'($urandom_range(63));
      shape  = tail_shape_type'($urandom_range(0, 6));
      case (shape)
         TAIL_FULL: begin
            repeat (3) push_char(rand_sym(), 1'b0);
            push_char(rand_sym(), 1'b1);
         end
         TAIL_TWO_PADS: begin
            if ($urandom_range(3) != 0) low_sx &= ~LEFTOVER_MASK_ONE;
            push_char(rand_sym(), 1'b0);
            push_char(sextet_char(low_sx), 1'b0);
            push_char(CHAR_PAD, 1'b0);
            push_char(CHAR_PAD, 1'b1);
         end
         TAIL_ONE_PAD: begin
            if ($urandom_range(3) != 0) low_sx &= ~LEFTOVER_MASK_TWO;
            push_char(rand_sym(), 1'b0);
            push_char(rand_sym(), 1'b0);
            push_char(sextet_char(low_sx), 1'b0);
            push_char(CHAR_PAD, 1'b1);
         end
         TAIL_TWO_BARE: begin
            if ($urandom_range(3) != 0) low_sx &= ~LEFTOVER_MASK_ONE;
            push_char(rand_sym(), 1'b0);
            push_char(sextet_char(low_sx), 1'b1);
         end
         TAIL_THREE_BARE: begin
            if ($urandom_range(3) != 0) low_sx &= ~LEFTOVER_MASK_TWO;
            push_char(rand_sym(), 1'b0);
            push_char(rand_sym(), 1'b0);
            push_char(sextet_char(low_sx), 1'b1);
         end
         TAIL_LONE: begin
            push_char(rand_sym(), 1'b1);
         end
         default: begin
            push_char(rand_sym(), 1'b0);
            push_char(rand_sym(), 1'b0);
            push_char(CHAR_PAD, 1'b0);
            push_char(rand_sym(), 1'b1);
         end
      endcase
   endfunction

   function automatic void set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 82; end
         IDLE_BOTH: begin send_idle_pct = 13; recv_stall_pct = 13; end
         default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endfunction

   // wait until every character is taken and every word has come
   task automatic wait_idle();
      do @(posedge clock); while (chars_left != 0 || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write, then a read back of the same register
   task automatic csr_write(input logic idx, input logic val);
      logic [CSR_ADDR_WIDTH-1:0] addr;
      addr = CSR_ADDR_WIDTH'({idx, 2'b00});
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_WIDTH'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // read setup
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_WIDTH'(val)) begin
         report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, prdata, val));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == CSR_ALLOW_MISSING_PADDING) begin
         cfg_allow_missing = val;
      end else begin
         cfg_ignore_leftover = val;
      end
   endtask

   // character driver: one word per handshake, next one taken from the queue
   always @(posedge clock) begin : char_driver
      char_item_type offered;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_char(offered);
            chars_left--;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered             = pending_chars.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.in_char    <= offered.in_char;
               req_chan.final_char <= offered.final_char;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the result side, started by a new ticket
   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left   <= RSP_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // word monitor: check each taken word against the oldest expectation
   always @(posedge clock) begin : word_monitor
      word_type got;
      word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte      = rsp_chan.out_byte;
            got.byte_valid    = rsp_chan.byte_valid;
            got.end_of_stream = rsp_chan.end_of_stream;
            got.decode_error  = rsp_chan.decode_error;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %0d unexpected: byte %02h v%0b eos%0b err%0b",
                  words_seen, got.out_byte, got.byte_valid, got.end_of_stream,
                  got.decode_error));
            end else begin
               want = expected_words.pop_front();
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.end_of_stream !== want.end_of_stream ||
                   got.decode_error !== want.decode_error) begin
                  report_mismatch($sformatf(
                     "word %0d: got byte %02h v%0b eos%0b err%0b, want %02h v%0b eos%0b err%0b",
                     words_seen, got.out_byte, got.byte_valid, got.end_of_stream,
                     got.decode_error, want.out_byte, want.byte_valid,
                     want.end_of_stream, want.decode_error));
               end
            end
            words_seen++;
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || psel || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // known values on every input from time zero
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_chan.valid      = 1'b0;
      req_chan.in_char    = 8'd0;
      req_chan.final_char = 1'b0;
      rsp_chan.ready      = 1'b0;
      chars_left          = 0;
      phase_chars         = 0;
      error_count         = 0;
      words_seen          = 0;
      hold_ticket         = 0;
      hold_served         = 0;
      hold_left           = 0;
      quiet_cycles        = 0;
      cfg_allow_missing   = 1'b0;
      cfg_ignore_leftover = 1'b0;
      grp_pos             = POS_FIRST;
      grp_sextet          = '{default: 6'd0};
      grp_third_pad       = 1'b0;
      str_error           = 1'b0;
      set_idle(IDLE_NONE);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      push_text(".z9A", 1'b0);        // alphabet extremes, middle group
      wait_idle();                    // sender pauses mid-string
      push_text("zw==", 1'b1);        // two pads, leftover bits nonzero
      push_char(8'hff, 1'b1);         // raw byte alone: bad char, lone final
      push_char(8'h00, 1'b0);         // raw zero, then short group, no pads
      push_text("B", 1'b1);
      wait_idle();

      // directed, short groups allowed, leftover bits ignored
      csr_write(CSR_ALLOW_MISSING_PADDING, 1'b1);
      csr_write(CSR_IGNORE_NONZERO_PAD_BITS, 1'b1);
      push_text("AB", 1'b1);          // one byte, no pads
      push_text("ABC", 1'b1);         // two bytes, no pads
      push_text("AB=C", 1'b0);        // pad then char, middle group
      push_text("AB=C", 1'b1);        // pad then char, final group
      wait_idle();

      // random phases over register settings and idling modes
      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_ALLOW_MISSING_PADDING, ALLOW_PLAN[p]);
         csr_write(CSR_IGNORE_NONZERO_PAD_BITS, IGNORE_PLAN[p]);
         set_idle(idle_mode_type'(p % 4));
         phase_chars = 0;
         if (p == 0) begin
            // rsp side holds off while characters keep coming; each lone
            // final gives a command of its own, more than the block can hold
            hold_ticket++;
            repeat (FILL_COMMANDS) push_char(rand_sym(), 1'b1);
         end
         while (phase_chars < PHASE_CHARS) begin
            gen_string();
         end
         wait_idle();
      end

      if (expected_words.size() != 0) begin
         report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
